// ----- hw/rtl/uer_pkg.sv -----
`default_nettype none
package uer_pkg;

	// measurement phase of the ranging sequence
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_RISE,
		PH_HIGH
	} phase_t;

	// sequencer state of the controller
	typedef enum logic [1:0] {
		CS_WAIT,
		CS_DIV,
		CS_FIN
	} ctl_state_t;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_TRIGGER_TICKS,
		REG_TIMEOUT_TICKS,
		REG_TICKS_PER_UNIT,
		REG_TIMEOUT_DISTANCE
	} reg_idx_t;

	localparam logic [7:0]  RST_TRIGGER_TICKS    = 8'd10;
	localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd30000;
	localparam logic [7:0]  RST_TICKS_PER_UNIT   = 8'd58;
	localparam logic [15:0] RST_TIMEOUT_DISTANCE = 16'd999;

	typedef struct packed {
		logic [7:0]  trigger_ticks;
		logic [15:0] timeout_ticks;
		logic [7:0]  ticks_per_unit;
		logic [15:0] timeout_distance;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic tick_go;
		logic div_step;
		logic div_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_div;
		logic div_last;
	} status_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ultrasonic_echo_ranger.sv -----
`default_nettype none
// Channel    | Direction | Handshake            | Payload
// input      | in        | in_valid / in_ready  | start_req, echo
// result     | out       | out_valid / out_ready| trigger, busy_res, done_res, timed_out, distance
// config     | in        | APB write, pready=1  | paddr[3:2] register, pwdata
//
// Each tick request yields one result. A tick that ends an echo measurement
// runs a shift-subtract divider, one quotient bit per cycle, before its result
// is registered. Every other tick registers its result directly.
// arst_n clears phase, counter and last distance and loads register defaults.
// A result waiting on out_ready holds further tick requests off.
module ultrasonic_echo_ranger #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        start_req,
	input  wire logic        echo,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             trigger,
	output logic             busy_res,
	output logic             done_res,
	output logic             timed_out,
	output logic [15:0]      distance,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	uer_pkg::cfg_t    cfg_q;
	uer_pkg::cmd_t    cmd;
	uer_pkg::status_t status;
	uer_pkg::reg_idx_t idx;

	assign pready = 1'b1;
	assign idx    = uer_pkg::reg_idx_t'(paddr[3:2]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks    <= uer_pkg::RST_TRIGGER_TICKS;
			cfg_q.timeout_ticks    <= uer_pkg::RST_TIMEOUT_TICKS;
			cfg_q.ticks_per_unit   <= uer_pkg::RST_TICKS_PER_UNIT;
			cfg_q.timeout_distance <= uer_pkg::RST_TIMEOUT_DISTANCE;
		end else if (psel && penable && pwrite) begin
			case (idx)
				uer_pkg::REG_TRIGGER_TICKS:    cfg_q.trigger_ticks    <= pwdata[7:0];
				uer_pkg::REG_TIMEOUT_TICKS:    cfg_q.timeout_ticks    <= pwdata[15:0];
				uer_pkg::REG_TICKS_PER_UNIT:   cfg_q.ticks_per_unit   <= pwdata[7:0];
				uer_pkg::REG_TIMEOUT_DISTANCE: cfg_q.timeout_distance <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		case (idx)
			uer_pkg::REG_TRIGGER_TICKS:    prdata = {24'd0, cfg_q.trigger_ticks};
			uer_pkg::REG_TIMEOUT_TICKS:    prdata = {16'd0, cfg_q.timeout_ticks};
			uer_pkg::REG_TICKS_PER_UNIT:   prdata = {24'd0, cfg_q.ticks_per_unit};
			uer_pkg::REG_TIMEOUT_DISTANCE: prdata = {16'd0, cfg_q.timeout_distance};
			default:                       prdata = 32'd0;
		endcase
	end

	uer_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	uer_dpath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.status    (status),
		.start_req (start_req),
		.echo      (echo),
		.trigger   (trigger),
		.busy_res  (busy_res),
		.done_res  (done_res),
		.timed_out (timed_out),
		.distance  (distance)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/uer_ctrl.sv -----
`default_nettype none
module uer_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire uer_pkg::status_t status,
	output uer_pkg::cmd_t       cmd
);

	uer_pkg::ctl_state_t state_q, state_next;
	logic out_valid_q;
	logic tick_go;

	// take a request only when waiting and the result slot frees up
	assign in_ready  = (state_q == uer_pkg::CS_WAIT) && (!out_valid_q || out_ready);
	assign tick_go   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			uer_pkg::CS_WAIT: begin
				if (tick_go && status.need_div) state_next = uer_pkg::CS_DIV;
			end
			uer_pkg::CS_DIV: begin
				if (status.div_last) state_next = uer_pkg::CS_FIN;
			end
			uer_pkg::CS_FIN: begin
				state_next = uer_pkg::CS_WAIT;
			end
			default: begin
				state_next = uer_pkg::CS_WAIT;
			end
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			uer_pkg::CS_WAIT: begin
				cmd.tick_go = tick_go;
			end
			uer_pkg::CS_DIV: begin
				cmd.div_step = 1'b1;
			end
			uer_pkg::CS_FIN: begin
				cmd.div_load = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// advance state and track the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= uer_pkg::CS_WAIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if ((cmd.tick_go && !status.need_div) || cmd.div_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/uer_dpath.sv -----
`default_nettype none
module uer_dpath #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire uer_pkg::cfg_t cfg,
	input  wire uer_pkg::cmd_t cmd,
	output uer_pkg::status_t   status,
	input  wire logic          start_req,
	input  wire logic          echo,
	output logic               trigger,
	output logic               busy_res,
	output logic               done_res,
	output logic               timed_out,
	output logic [15:0]        distance
);

	localparam int CW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int STEPW = $clog2(COUNT_BITS);

	uer_pkg::phase_t phase_q, phase_next;
	logic [COUNT_BITS-1:0] cnt_q, cnt_next, cnt_inc;
	logic [15:0] last_dist_q;
	logic trig_n, done_n, tmo_n, div_n;
	logic limit_hit;

	logic [COUNT_BITS-1:0] dvd_q;
	logic [7:0]            rem_q, dvs_q, rem_next;
	logic                  dvs_zero_q;
	logic [STEPW-1:0]      step_q;
	logic [8:0]            trial;
	logic                  ge;
	logic [15:0]           quot;

	assign cnt_inc   = cnt_q + COUNT_BITS'(1);
	assign limit_hit = (CW'(cnt_q) >= CW'(cfg.timeout_ticks)) || (&cnt_q);

	// per-tick phase rule
	always_comb begin
		phase_next = phase_q;
		cnt_next   = cnt_q;
		trig_n     = 1'b0;
		done_n     = 1'b0;
		tmo_n      = 1'b0;
		div_n      = 1'b0;
		case (phase_q)
			uer_pkg::PH_IDLE: begin
				if (start_req) begin
					trig_n = 1'b1;
					if (cfg.trigger_ticks <= 8'd1) begin
						phase_next = uer_pkg::PH_RISE;
						cnt_next   = '0;
					end else begin
						phase_next = uer_pkg::PH_TRIG;
						cnt_next   = COUNT_BITS'(1);
					end
				end
			end
			uer_pkg::PH_TRIG: begin
				trig_n = 1'b1;
				if (cnt_inc >= COUNT_BITS'(cfg.trigger_ticks)) begin
					phase_next = uer_pkg::PH_RISE;
					cnt_next   = '0;
				end else begin
					cnt_next = cnt_inc;
				end
			end
			uer_pkg::PH_RISE: begin
				if (echo) begin
					phase_next = uer_pkg::PH_HIGH;
					cnt_next   = COUNT_BITS'(1);
				end else if (limit_hit) begin
					done_n = 1'b1;
					tmo_n  = 1'b1;
				end else begin
					cnt_next = cnt_inc;
				end
			end
			uer_pkg::PH_HIGH: begin
				if (!echo) begin
					done_n = 1'b1;
					div_n  = 1'b1;
				end else if (limit_hit) begin
					done_n = 1'b1;
					tmo_n  = 1'b1;
				end else begin
					cnt_next = cnt_inc;
				end
			end
			default: begin
				phase_next = uer_pkg::PH_IDLE;
			end
		endcase
		if (tmo_n || div_n) begin
			phase_next = uer_pkg::PH_IDLE;
			cnt_next   = '0;
		end
	end

	assign status.need_div = div_n;
	assign status.div_last = (step_q == '0);

	// restoring division step, one quotient bit per cycle
	assign trial    = {rem_q, dvd_q[COUNT_BITS-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign rem_next = ge ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];

	// saturate the quotient, all ones for a zero divisor
	always_comb begin
		if (dvs_zero_q || (CW'(dvd_q) > CW'(16'hFFFF))) begin
			quot = 16'hFFFF;
		end else begin
			quot = 16'(dvd_q);
		end
	end

	// measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= uer_pkg::PH_IDLE;
			cnt_q       <= '0;
			last_dist_q <= '0;
		end else begin
			if (cmd.tick_go) begin
				phase_q <= phase_next;
				cnt_q   <= cnt_next;
				if (tmo_n) last_dist_q <= cfg.timeout_distance;
			end
			if (cmd.div_load) last_dist_q <= quot;
		end
	end

	// divider registers
	always_ff @(posedge clk) begin
		if (cmd.tick_go && div_n) begin
			dvd_q      <= cnt_q;
			rem_q      <= '0;
			dvs_q      <= cfg.ticks_per_unit;
			dvs_zero_q <= (cfg.ticks_per_unit == 8'd0);
			step_q     <= STEPW'(COUNT_BITS - 1);
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[COUNT_BITS-2:0], ge};
			rem_q  <= rem_next;
			step_q <= step_q - STEPW'(1);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.tick_go) begin
			trigger   <= trig_n;
			busy_res  <= (phase_next != uer_pkg::PH_IDLE);
			done_res  <= done_n;
			timed_out <= tmo_n;
			if (!div_n) distance <= tmo_n ? cfg.timeout_distance : last_dist_q;
		end
		if (cmd.div_load) distance <= quot;
	end

endmodule
`default_nettype wire

// ----- tb/sv/echo_range_checker.sv -----
module echo_range_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        start_req,
	input  logic        echo,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        trigger,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic        timed_out,
	input  logic [15:0] distance,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        wrap_up,
	output int          fail_count
);

	localparam int          COUNT_BITS = 16;
	localparam int unsigned COUNT_TOP  = (1 << COUNT_BITS) - 1;

	typedef struct packed {
		logic        trigger;
		logic        busy;
		logic        done;
		logic        tmo;
		logic [15:0] dist_val;
	} tick_result_t;

	// register copies as seen on the configuration port
	int unsigned trig_len;
	int unsigned wait_limit;
	int unsigned unit_div;
	int unsigned timeout_dist;

	// ranging state
	uer_pkg::phase_t ph;
	int unsigned     tick_cnt;
	logic [15:0]     last_dist;

	tick_result_t pending_results[$];
	tick_result_t want_r;
	int           err_count;
	bit           wrapped;

	assign fail_count = err_count;

	function automatic bit wait_expired();
		return tick_cnt >= wait_limit || tick_cnt >= COUNT_TOP;
	endfunction

	// advance the ranging state by one tick and return the expected result
	function automatic tick_result_t range_tick(logic s, logic e);
		tick_result_t r;
		int unsigned  quot;
		r = '0;
		case (ph)
			uer_pkg::PH_IDLE: begin
				if (s) begin
					r.trigger = 1'b1;
					tick_cnt = 1;
					if (tick_cnt >= trig_len) begin
						ph = uer_pkg::PH_RISE;
						tick_cnt = 0;
					end else begin
						ph = uer_pkg::PH_TRIG;
					end
				end
			end
			uer_pkg::PH_TRIG: begin
				r.trigger = 1'b1;
				tick_cnt = (tick_cnt + 1) & COUNT_TOP;
				if (tick_cnt >= trig_len) begin
					ph = uer_pkg::PH_RISE;
					tick_cnt = 0;
				end
			end
			uer_pkg::PH_RISE: begin
				if (e) begin
					ph = uer_pkg::PH_HIGH;
					tick_cnt = 1;
				end else if (wait_expired()) begin
					r.done = 1'b1;
					r.tmo = 1'b1;
				end else begin
					tick_cnt++;
				end
			end
			default: begin
				if (!e) begin
					// falling echo: divide width, zero divisor gives all ones
					if (unit_div == 0) quot = 16'hFFFF;
					else quot = tick_cnt / unit_div;
					if (quot > 16'hFFFF) quot = 16'hFFFF;
					last_dist = quot[15:0];
					r.done = 1'b1;
					ph = uer_pkg::PH_IDLE;
					tick_cnt = 0;
				end else if (wait_expired()) begin
					r.done = 1'b1;
					r.tmo = 1'b1;
				end else begin
					tick_cnt++;
				end
			end
		endcase
		if (r.tmo) begin
			last_dist = timeout_dist[15:0];
			ph = uer_pkg::PH_IDLE;
			tick_cnt = 0;
		end
		r.busy = (ph != uer_pkg::PH_IDLE);
		r.dist_val = last_dist;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_len     = uer_pkg::RST_TRIGGER_TICKS;
			wait_limit   = uer_pkg::RST_TIMEOUT_TICKS;
			unit_div     = uer_pkg::RST_TICKS_PER_UNIT;
			timeout_dist = uer_pkg::RST_TIMEOUT_DISTANCE;
			ph           = uer_pkg::PH_IDLE;
			tick_cnt     = 0;
			last_dist    = '0;
			err_count    = 0;
			wrapped      = 1'b0;
			pending_results.delete();
		end else begin
			// retire the oldest expectation on each accepted result
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					err_count++;
					$display("%0t: result with no request pending, expected none, actual %0h",
						$time, {trigger, busy_res, done_res, timed_out, distance});
				end else begin
					want_r = pending_results.pop_front();
					check_field("trigger", want_r.trigger, trigger);
					check_field("busy_res", want_r.busy, busy_res);
					check_field("done_res", want_r.done, done_res);
					check_field("timed_out", want_r.tmo, timed_out);
					check_field("distance", want_r.dist_val, distance);
				end
			end
			// predict each accepted request
			if (in_valid && in_ready)
				pending_results.push_back(range_tick(start_req, echo));
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (uer_pkg::reg_idx_t'(paddr[3:2]))
					uer_pkg::REG_TRIGGER_TICKS:    trig_len     = pwdata[7:0];
					uer_pkg::REG_TIMEOUT_TICKS:    wait_limit   = pwdata[15:0];
					uer_pkg::REG_TICKS_PER_UNIT:   unit_div     = pwdata[7:0];
					uer_pkg::REG_TIMEOUT_DISTANCE: timeout_dist = pwdata[15:0];
					default: ;
				endcase
			end
			// count expectations that never got a result
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (pending_results.size() != 0) begin
					err_count += pending_results.size();
					$display("%0t: results outstanding, expected 0, actual %0d",
						$time, pending_results.size());
				end
			end
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        start_req = 1'b0;
	logic        echo      = 1'b0;
	logic        out_ready = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic        wrap_up   = 1'b0;

	logic        in_ready;
	logic        out_valid;
	logic        trigger;
	logic        busy_res;
	logic        done_res;
	logic        timed_out;
	logic [15:0] distance;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;

	int          in_idle_pct  = 11;
	int          out_idle_pct = 64;
	int          n_req = 0;
	int          n_res = 0;
	int          cycles = 0;
	int          items_sent = 0;

	// stimulus copies of the registers, used to shape sequences
	int unsigned trig_len;
	int unsigned tmo_lim;

	ultrasonic_echo_ranger i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_req(start_req),
		.echo(echo),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trigger(trigger),
		.busy_res(busy_res),
		.done_res(done_res),
		.timed_out(timed_out),
		.distance(distance),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	echo_range_checker u_range_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_req(start_req),
		.echo(echo),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.trigger(trigger),
		.busy_res(busy_res),
		.done_res(done_res),
		.timed_out(timed_out),
		.distance(distance),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.wrap_up(wrap_up),
		.fail_count(fail_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stall the result side at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// count handshakes and stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (in_valid && in_ready) n_req <= n_req + 1;
		if (out_valid && out_ready) n_res <= n_res + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic push_tick(input bit s, input bit e);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		start_req <= s;
		echo      <= e;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// drop valid and hold until every request has its result
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (n_req != n_res);
	endtask

	task automatic write_reg(input uer_pkg::reg_idx_t idx, input int unsigned val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_cfg(input int unsigned tt, input int unsigned to,
			input int unsigned tpu, input int unsigned td);
		settle();
		write_reg(uer_pkg::REG_TRIGGER_TICKS, tt);
		write_reg(uer_pkg::REG_TIMEOUT_TICKS, to);
		write_reg(uer_pkg::REG_TICKS_PER_UNIT, tpu);
		write_reg(uer_pkg::REG_TIMEOUT_DISTANCE, td);
		trig_len = tt;
		tmo_lim  = to;
	endtask

	// one ranging sequence: start, trigger ticks, rise wait, echo width, fall
	task automatic measure(input int unsigned rise_wait, input int unsigned width);
		push_tick(1'b1, $urandom_range(1));
		for (int i = 1; i < trig_len; i++)
			push_tick($urandom_range(3) == 0, $urandom_range(1));
		repeat (rise_wait) push_tick($urandom_range(3) == 0, 1'b0);
		repeat (width) push_tick($urandom_range(7) == 0, 1'b1);
		push_tick($urandom_range(1), 1'b0);
	endtask

	task automatic run_phase(input int budget, input int unsigned rise_max,
			input int unsigned width_max);
		int          target;
		int unsigned rise_cap;
		int unsigned width_cap;
		int          kind;
		target    = items_sent + budget;
		rise_cap  = (tmo_lim + 1 < rise_max) ? tmo_lim + 1 : rise_max;
		width_cap = (tmo_lim + 1 < width_max) ? tmo_lim + 1 : width_max;
		while (items_sent < target) begin
			kind = $urandom_range(19);
			if (kind == 0) begin
				settle();
			end else if (kind < 4) begin
				repeat ($urandom_range(6, 1))
					push_tick($urandom_range(7) == 0, $urandom_range(1));
			end else begin
				measure($urandom_range(rise_cap), $urandom_range(width_cap, 1));
			end
		end
	endtask

	initial begin
		trig_len = uer_pkg::RST_TRIGGER_TICKS;
		tmo_lim  = uer_pkg::RST_TIMEOUT_TICKS;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short trigger, tight limit, unit divisor
		load_cfg(2, 3, 1, 16'hFFFF);
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		// start ignored during trigger and on the done tick
		push_tick(1'b1, 1'b1);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b1, 1'b1);
		push_tick(1'b1, 1'b0);
		// echo ignored during trigger, then time out waiting for the rise
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b1);
		repeat (4) push_tick(1'b0, 1'b0);
		// echo held high past the limit
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b0);
		repeat (3) push_tick(1'b0, 1'b1);
		push_tick(1'b1, 1'b1);
		// zero trigger length and zero divisor
		load_cfg(0, 16'hFFFF, 0, 16'h5A5A);
		push_tick(1'b1, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);

		// sender idles lightly, receiver heavily
		load_cfg(uer_pkg::RST_TRIGGER_TICKS, uer_pkg::RST_TIMEOUT_TICKS,
			uer_pkg::RST_TICKS_PER_UNIT, uer_pkg::RST_TIMEOUT_DISTANCE);
		run_phase(50, 12, 40);
		load_cfg($urandom_range(4, 1), $urandom_range(24, 1), $urandom_range(6, 1),
			$urandom_range(16'hFFFF));
		run_phase(40, 30, 30);

		// swap the idling sides; largest trigger, timeout and divisor values
		settle();
		in_idle_pct  = 64;
		out_idle_pct = 11;
		load_cfg(255, 16'hFFFF, 255, 0);
		measure(3, $urandom_range(20, 1));
		load_cfg($urandom_range(4, 1), $urandom_range(24, 1), $urandom_range(6, 1),
			$urandom_range(16'hFFFF));
		run_phase(40, 30, 30);

		// no idling on either side
		settle();
		in_idle_pct  = 0;
		out_idle_pct = 0;
		load_cfg(1, 1, 1, 16'hFFFF);
		run_phase(30, 4, 4);
		load_cfg($urandom_range(8, 1), $urandom_range(400, 20), $urandom_range(40, 1),
			$urandom_range(16'hFFFF));
		run_phase(40, 40, 60);

		// drain, let the block settle, then collect the verdict
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
